// ===== hdl/vec3_pkg.sv =====
`timescale 1ns / 1ps

package vec3_pkg;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_ADD_S     = 4'd2,
        OP_SUB_S     = 4'd3,
        OP_MUL       = 4'd4,
        OP_DIV       = 4'd5,
        OP_NEG       = 4'd6,
        OP_DOT       = 4'd7,
        OP_CROSS     = 4'd8,
        OP_NORM      = 4'd9,
        OP_NORMSQ    = 4'd10,
        OP_NORMALIZE = 4'd11,
        OP_EQUAL     = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    localparam int TOL_WIDTH = 16;

    // per-word control that follows the data down the pipe
    typedef struct packed {
        op_t  op;
        logic sat;
        logic eq;
        logic div_zero;
    } ctrl_t;

endpackage

// ===== hdl/vec3_if.sv =====
`timescale 1ns / 1ps

interface vec3_req_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic [3:0]          req_type;
    logic signed [W-1:0] ax;
    logic signed [W-1:0] ay;
    logic signed [W-1:0] az;
    logic signed [W-1:0] bx;
    logic signed [W-1:0] by;
    logic signed [W-1:0] bz;
    logic signed [W-1:0] scalar_operand;

    modport source (
        output valid, req_type, ax, ay, az, bx, by, bz, scalar_operand,
        input  ready
    );
    modport sink (
        input  valid, req_type, ax, ay, az, bx, by, bz, scalar_operand,
        output ready
    );
endinterface

interface vec3_rsp_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rx;
    logic signed [W-1:0] ry;
    logic signed [W-1:0] rz;
    logic                is_equal;
    logic [1:0]          status;

    modport source (
        output valid, rx, ry, rz, is_equal, status,
        input  ready
    );
    modport sink (
        input  valid, rx, ry, rz, is_equal, status,
        output ready
    );
endinterface

// ===== hdl/vec3_front.sv =====
`timescale 1ns / 1ps

module vec3_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [3:0]            req_type,
    input  logic signed [W-1:0]   ax,
    input  logic signed [W-1:0]   ay,
    input  logic signed [W-1:0]   az,
    input  logic signed [W-1:0]   bx,
    input  logic signed [W-1:0]   by,
    input  logic signed [W-1:0]   bz,
    input  logic signed [W-1:0]   s,
    input  logic [vec3_pkg::TOL_WIDTH-1:0] tol,
    output logic                  out_valid,
    output vec3_pkg::ctrl_t       ctrl,
    output logic signed [W-1:0]   res [3],
    output logic signed [W-1:0]   a [3],
    output logic                  s_neg,
    output logic [W-1:0]          s_mag,
    output logic [2*W-1:0]        rad
);

    localparam int PW = 2 * W + 2;
    localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] CMAX = ~CMIN;

    // returns {saturated, value}
    function automatic logic [W:0] clamp(input logic signed [PW-1:0] v);
        logic fits;
        fits = (&v[PW-1:W-1]) || !(|v[PW-1:W-1]);
        if (fits)
            return {1'b0, v[W-1:0]};
        else
            return {1'b1, v[PW-1] ? CMIN : CMAX};
    endfunction

    // stage A: operand selection for the six multipliers
    logic                va_reg;
    vec3_pkg::op_t       op_a_reg;
    logic signed [W-1:0] a_a_reg [3];
    logic signed [W-1:0] b_a_reg [3];
    logic signed [W-1:0] s_a_reg;
    logic signed [W-1:0] ma_reg [6];
    logic signed [W-1:0] mb_reg [6];
    logic signed [W-1:0] ma_next [6];
    logic signed [W-1:0] mb_next [6];
    vec3_pkg::op_t       op_in;

    assign op_in = vec3_pkg::op_t'(req_type);

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            ma_next[j] = '0;
            mb_next[j] = '0;
        end
        case (op_in)
            vec3_pkg::OP_MUL:
            begin
                ma_next[0] = ax; mb_next[0] = s;
                ma_next[1] = ay; mb_next[1] = s;
                ma_next[2] = az; mb_next[2] = s;
            end
            vec3_pkg::OP_DOT:
            begin
                ma_next[0] = ax; mb_next[0] = bx;
                ma_next[1] = ay; mb_next[1] = by;
                ma_next[2] = az; mb_next[2] = bz;
            end
            vec3_pkg::OP_CROSS:
            begin
                ma_next[0] = ay; mb_next[0] = bz;
                ma_next[1] = az; mb_next[1] = by;
                ma_next[2] = az; mb_next[2] = bx;
                ma_next[3] = ax; mb_next[3] = bz;
                ma_next[4] = ax; mb_next[4] = by;
                ma_next[5] = ay; mb_next[5] = bx;
            end
            vec3_pkg::OP_NORM, vec3_pkg::OP_NORMSQ, vec3_pkg::OP_NORMALIZE:
            begin
                ma_next[0] = ax; mb_next[0] = ax;
                ma_next[1] = ay; mb_next[1] = ay;
                ma_next[2] = az; mb_next[2] = az;
            end
            default:
            begin
            end
        endcase
    end

    // stage B: products
    logic                  vb_reg;
    vec3_pkg::op_t         op_b_reg;
    logic signed [W-1:0]   a_b_reg [3];
    logic signed [W-1:0]   b_b_reg [3];
    logic signed [W-1:0]   s_b_reg;
    logic signed [2*W-1:0] p_b_reg [6];

    // stage C: sums, differences and clamping
    logic                vc_reg;
    vec3_pkg::ctrl_t     ctrl_c_reg;
    logic signed [W-1:0] res_c_reg [3];
    logic signed [W-1:0] a_c_reg [3];
    logic                s_neg_c_reg;
    logic [W-1:0]        s_mag_c_reg;
    logic [2*W-1:0]      rad_c_reg;

    logic signed [PW-1:0] sum3;
    logic signed [PW-1:0] lane_w [3];
    logic [W:0]           lane_c [3];
    logic signed [W:0]    diff [3];
    logic [W:0]           absd [3];
    vec3_pkg::ctrl_t      ctrl_next;
    logic signed [W-1:0]  res_next [3];
    logic                 eq_all;

    always_comb
    begin
        sum3 = PW'(p_b_reg[0]) + PW'(p_b_reg[1]) + PW'(p_b_reg[2]);
        for (int i = 0; i < 3; i++)
            lane_w[i] = '0;
        case (op_b_reg)
            vec3_pkg::OP_ADD:
                for (int i = 0; i < 3; i++)
                    lane_w[i] = PW'(a_b_reg[i]) + PW'(b_b_reg[i]);
            vec3_pkg::OP_SUB:
                for (int i = 0; i < 3; i++)
                    lane_w[i] = PW'(a_b_reg[i]) - PW'(b_b_reg[i]);
            vec3_pkg::OP_ADD_S:
                for (int i = 0; i < 3; i++)
                    lane_w[i] = PW'(a_b_reg[i]) + PW'(s_b_reg);
            vec3_pkg::OP_SUB_S:
                for (int i = 0; i < 3; i++)
                    lane_w[i] = PW'(a_b_reg[i]) - PW'(s_b_reg);
            vec3_pkg::OP_MUL:
                for (int i = 0; i < 3; i++)
                    lane_w[i] = PW'(p_b_reg[i]) >>> F;
            vec3_pkg::OP_NEG:
                for (int i = 0; i < 3; i++)
                    lane_w[i] = -PW'(a_b_reg[i]);
            vec3_pkg::OP_DOT, vec3_pkg::OP_NORMSQ:
                lane_w[0] = sum3 >>> F;
            vec3_pkg::OP_CROSS:
            begin
                lane_w[0] = (PW'(p_b_reg[0]) - PW'(p_b_reg[1])) >>> F;
                lane_w[1] = (PW'(p_b_reg[2]) - PW'(p_b_reg[3])) >>> F;
                lane_w[2] = (PW'(p_b_reg[4]) - PW'(p_b_reg[5])) >>> F;
            end
            default:
            begin
            end
        endcase

        eq_all = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            lane_c[i]   = clamp(lane_w[i]);
            res_next[i] = lane_c[i][W-1:0];
            diff[i]     = (W+1)'(a_b_reg[i]) - (W+1)'(b_b_reg[i]);
            absd[i]     = diff[i][W] ? (W+1)'(-diff[i]) : (W+1)'(diff[i]);
            if (absd[i] > (W+1)'(tol))
                eq_all = 1'b0;
        end

        ctrl_next.op       = op_b_reg;
        ctrl_next.sat      = lane_c[0][W] | lane_c[1][W] | lane_c[2][W];
        ctrl_next.eq       = (op_b_reg == vec3_pkg::OP_EQUAL) && eq_all;
        ctrl_next.div_zero = (op_b_reg == vec3_pkg::OP_DIV) && (s_b_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_a_reg   <= op_in;
            a_a_reg[0] <= ax;
            a_a_reg[1] <= ay;
            a_a_reg[2] <= az;
            b_a_reg[0] <= bx;
            b_a_reg[1] <= by;
            b_a_reg[2] <= bz;
            s_a_reg    <= s;
            for (int j = 0; j < 6; j++)
            begin
                ma_reg[j] <= ma_next[j];
                mb_reg[j] <= mb_next[j];
            end

            op_b_reg <= op_a_reg;
            a_b_reg  <= a_a_reg;
            b_b_reg  <= b_a_reg;
            s_b_reg  <= s_a_reg;
            for (int j = 0; j < 6; j++)
                p_b_reg[j] <= ma_reg[j] * mb_reg[j];

            ctrl_c_reg  <= ctrl_next;
            res_c_reg   <= res_next;
            a_c_reg     <= a_b_reg;
            s_neg_c_reg <= s_b_reg[W-1];
            s_mag_c_reg <= s_b_reg[W-1] ? W'(-s_b_reg) : W'(s_b_reg);
            rad_c_reg   <= sum3[2*W-1:0];
        end
    end

    assign out_valid = vc_reg;
    assign ctrl      = ctrl_c_reg;
    assign res       = res_c_reg;
    assign a         = a_c_reg;
    assign s_neg     = s_neg_c_reg;
    assign s_mag     = s_mag_c_reg;
    assign rad       = rad_c_reg;

endmodule

// ===== hdl/vec3_sqrt.sv =====
`timescale 1ns / 1ps

// one result bit per stage, restoring square root
module vec3_sqrt #(
    parameter int W    = 32,
    parameter int SB_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*W-1:0]    rad,
    input  logic [SB_W-1:0]   sb_in,
    output logic              out_valid,
    output logic [W-1:0]      root,
    output logic [SB_W-1:0]   sb_out
);

    logic              v_reg    [W];
    logic [W:0]        rem_reg  [W];
    logic [W-1:0]      root_reg [W];
    logic [2*W-1:0]    rad_reg  [W];
    logic [SB_W-1:0]   sb_reg   [W];

    for (genvar k = 0; k < W; k++)
    begin : g_step
        logic            v_p;
        logic [W:0]      rem_p;
        logic [W-1:0]    root_p;
        logic [2*W-1:0]  rad_p;
        logic [SB_W-1:0] sb_p;
        logic [W+2:0]    cat;
        logic [W+2:0]    trial;
        logic [W+2:0]    sub;
        logic            take;

        if (k == 0)
        begin : g_first
            assign v_p    = in_valid;
            assign rem_p  = '0;
            assign root_p = '0;
            assign rad_p  = rad;
            assign sb_p   = sb_in;
        end
        else
        begin : g_rest
            assign v_p    = v_reg[k-1];
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign rad_p  = rad_reg[k-1];
            assign sb_p   = sb_reg[k-1];
        end

        always_comb
        begin
            cat   = {rem_p, rad_p[2*W-1:2*W-2]};
            trial = {1'b0, root_p, 2'b01};
            sub   = cat - trial;
            take  = (cat >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? sub[W:0] : cat[W:0];
                root_reg[k] <= {root_p[W-2:0], take};
                rad_reg[k]  <= {rad_p[2*W-3:0], 2'b00};
                sb_reg[k]   <= sb_p;
            end
        end
    end

    assign out_valid = v_reg[W-1];
    assign root      = root_reg[W-1];
    assign sb_out    = sb_reg[W-1];

endmodule

// ===== hdl/vec3_div.sv =====
`timescale 1ns / 1ps

// three restoring dividers sharing one divisor, one quotient bit per stage
module vec3_div #(
    parameter int W    = 32,
    parameter int F    = 16,
    parameter int SB_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W-1:0]      num [3],
    input  logic [W-1:0]      den,
    input  logic [SB_W-1:0]   sb_in,
    output logic              out_valid,
    output logic [W+F-1:0]    quo [3],
    output logic [SB_W-1:0]   sb_out
);

    localparam int QW = W + F;

    logic            v_reg   [QW];
    logic [W-1:0]    rem_reg [QW][3];
    logic [QW-1:0]   num_reg [QW][3];
    logic [W-1:0]    den_reg [QW];
    logic [SB_W-1:0] sb_reg  [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic            v_p;
        logic [W-1:0]    rem_p [3];
        logic [QW-1:0]   num_p [3];
        logic [W-1:0]    den_p;
        logic [SB_W-1:0] sb_p;
        logic [W:0]      cat   [3];
        logic [W:0]      sub   [3];
        logic            take  [3];

        if (k == 0)
        begin : g_first
            assign v_p  = in_valid;
            assign den_p = den;
            assign sb_p = sb_in;
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_p[i] = '0;
                assign num_p[i] = QW'(num[i]) << F;
            end
        end
        else
        begin : g_rest
            assign v_p   = v_reg[k-1];
            assign den_p = den_reg[k-1];
            assign sb_p  = sb_reg[k-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_p[i] = rem_reg[k-1][i];
                assign num_p[i] = num_reg[k-1][i];
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                cat[i]  = {rem_p[i], num_p[i][QW-1]};
                sub[i]  = cat[i] - {1'b0, den_p};
                take[i] = (cat[i] >= {1'b0, den_p});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[k][i] <= take[i] ? sub[i][W-1:0] : cat[i][W-1:0];
                    num_reg[k][i] <= {num_p[i][QW-2:0], take[i]};
                end
                den_reg[k] <= den_p;
                sb_reg[k]  <= sb_p;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign sb_out    = sb_reg[QW-1];
    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign quo[i] = num_reg[QW-1][i];
    end

endmodule

// ===== hdl/vector3_alu.sv =====
`timescale 1ns / 1ps
// path from request to response: front stages A, B and C, the square root, the dividers, then the output register
// throughput: one word per cycle while the pipe is not frozen; the square root (one bit per stage) and the
// dividers (one quotient bit per stage) are fully pipelined, every opcode takes the same path
// back-pressure freezes the whole pipe, empty slots included, while the output word waits
// reset: rst_n clears every valid bit and sets the equal tolerance (tol_reg) to zero

module vector3_alu #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    vec3_req_if.sink                      req,
    vec3_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [vec3_pkg::TOL_WIDTH-1:0] cfg_wdata
);

    localparam int W      = COMP_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int QW     = W + F;
    localparam int CTRL_W = $bits(vec3_pkg::ctrl_t);
    localparam int SB_W   = CTRL_W + 7 * W + 1;
    localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] CMAX = ~CMIN;

    logic [vec3_pkg::TOL_WIDTH-1:0] tol_reg;
    logic en;
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    // front: operands, products, sums
    logic                f_valid;
    vec3_pkg::ctrl_t     f_ctrl;
    logic signed [W-1:0] f_res [3];
    logic signed [W-1:0] f_a [3];
    logic                f_s_neg;
    logic [W-1:0]        f_s_mag;
    logic [2*W-1:0]      f_rad;

    vec3_front #(.W(W), .F(F)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .req_type  (req.req_type),
        .ax        (req.ax),
        .ay        (req.ay),
        .az        (req.az),
        .bx        (req.bx),
        .by        (req.by),
        .bz        (req.bz),
        .s         (req.scalar_operand),
        .tol       (tol_reg),
        .out_valid (f_valid),
        .ctrl      (f_ctrl),
        .res       (f_res),
        .a         (f_a),
        .s_neg     (f_s_neg),
        .s_mag     (f_s_mag),
        .rad       (f_rad)
    );

    // square root of the sum of squares
    logic [SB_W-1:0] q_sb_in;
    logic [SB_W-1:0] q_sb_out;
    logic            q_valid;
    logic [W-1:0]    q_root;

    assign q_sb_in = {f_ctrl, f_res[0], f_res[1], f_res[2], f_a[0], f_a[1], f_a[2],
                      f_s_neg, f_s_mag};

    vec3_sqrt #(.W(W), .SB_W(SB_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .rad       (f_rad),
        .sb_in     (q_sb_in),
        .out_valid (q_valid),
        .root      (q_root),
        .sb_out    (q_sb_out)
    );

    vec3_pkg::ctrl_t     q_ctrl;
    logic signed [W-1:0] q_res [3];
    logic signed [W-1:0] q_a [3];
    logic                q_s_neg;
    logic [W-1:0]        q_s_mag;
    logic [W-1:0]        d_num [3];
    logic [W-1:0]        d_den;
    logic [SB_W-1:0]     d_sb_in;

    assign {q_ctrl, q_res[0], q_res[1], q_res[2], q_a[0], q_a[1], q_a[2],
            q_s_neg, q_s_mag} = q_sb_out;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d_num[i] = q_a[i][W-1] ? W'(-q_a[i]) : W'(q_a[i]);
        // divide uses the scalar, normalise uses the norm
        d_den = (q_ctrl.op == vec3_pkg::OP_DIV) ? q_s_mag : q_root;
    end

    assign d_sb_in = {q_ctrl, q_res[0], q_res[1], q_res[2], q_a[0], q_a[1], q_a[2],
                      q_s_neg, q_root};

    logic            d_valid;
    logic [QW-1:0]   d_quo [3];
    logic [SB_W-1:0] d_sb_out;

    vec3_div #(.W(W), .F(F), .SB_W(SB_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .num       (d_num),
        .den       (d_den),
        .sb_in     (d_sb_in),
        .out_valid (d_valid),
        .quo       (d_quo),
        .sb_out    (d_sb_out)
    );

    vec3_pkg::ctrl_t     e_ctrl;
    logic signed [W-1:0] e_res [3];
    logic signed [W-1:0] e_a [3];
    logic                e_s_neg;
    logic [W-1:0]        e_root;

    assign {e_ctrl, e_res[0], e_res[1], e_res[2], e_a[0], e_a[1], e_a[2],
            e_s_neg, e_root} = d_sb_out;

    // sign, clamp and final selection
    logic signed [QW:0]  sq [3];
    logic                q_sat [3];
    logic [W-1:0]        q_val [3];
    logic                neg_q;
    logic [W-1:0]        r_next [3];
    logic                sat_next;
    vec3_pkg::status_t   status_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_q = e_a[i][W-1] ^ ((e_ctrl.op == vec3_pkg::OP_DIV) && e_s_neg);
            sq[i] = neg_q ? -(QW+1)'(d_quo[i]) : (QW+1)'(d_quo[i]);
            if ((&sq[i][QW:W-1]) || !(|sq[i][QW:W-1]))
            begin
                q_sat[i] = 1'b0;
                q_val[i] = sq[i][W-1:0];
            end
            else
            begin
                q_sat[i] = 1'b1;
                q_val[i] = sq[i][QW] ? CMIN : CMAX;
            end
            r_next[i] = e_res[i];
        end
        sat_next = e_ctrl.sat;

        case (e_ctrl.op)
            vec3_pkg::OP_DIV:
            begin
                if (!e_ctrl.div_zero)
                begin
                    for (int i = 0; i < 3; i++)
                        r_next[i] = q_val[i];
                    sat_next = q_sat[0] | q_sat[1] | q_sat[2];
                end
            end
            vec3_pkg::OP_NORMALIZE:
            begin
                // a zero vector comes back as it is
                if (e_root == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        r_next[i] = e_a[i];
                    sat_next = 1'b0;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        r_next[i] = q_val[i];
                    sat_next = q_sat[0] | q_sat[1] | q_sat[2];
                end
            end
            vec3_pkg::OP_NORM:
            begin
                r_next[0] = e_root[W-1] ? CMAX : e_root;
                sat_next  = e_root[W-1];
            end
            default:
            begin
            end
        endcase

        if (e_ctrl.div_zero)
            status_next = vec3_pkg::ST_DIV_ZERO;
        else if (sat_next)
            status_next = vec3_pkg::ST_SAT;
        else
            status_next = vec3_pkg::ST_OK;
    end

    logic signed [W-1:0] rx_reg;
    logic signed [W-1:0] ry_reg;
    logic signed [W-1:0] rz_reg;
    logic                eq_reg;
    logic [1:0]          status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg     <= r_next[0];
            ry_reg     <= r_next[1];
            rz_reg     <= r_next[2];
            eq_reg     <= e_ctrl.eq;
            status_reg <= status_next;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.rx       = rx_reg;
    assign rsp.ry       = ry_reg;
    assign rsp.rz       = rz_reg;
    assign rsp.is_equal = eq_reg;
    assign rsp.status   = status_reg;

endmodule
